// ----- design/bbsr_pkg.sv -----
package bbsr_pkg;

    localparam int MAX_BYTES_DEF = 16;

    typedef enum logic [3:0] {
        OP_WRITE = 4'd0,
        OP_READ  = 4'd1,
        OP_SHL   = 4'd2,
        OP_SHR   = 4'd3,
        OP_ROTL  = 4'd4,
        OP_ROTR  = 4'd5,
        OP_ALL   = 4'd6,
        OP_ANY   = 4'd7,
        OP_NONE  = 4'd8
    } op_t;

    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_LE     = 2'd1;
    localparam logic [1:0] REG_INDEP  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_EXEC,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic exec;
    } cmd_t;

endpackage

// ----- design/bbsr_ctrl.sv -----
module bbsr_ctrl
    import bbsr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PREP;
            ST_PREP: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_DONE);
        cmd.load  = (state_reg == ST_IDLE) && in_valid;
        cmd.prep  = (state_reg == ST_PREP);
        cmd.exec  = (state_reg == ST_EXEC);
    end

endmodule

// ----- design/bbsr_dp.sv -----
module bbsr_dp
    import bbsr_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic [3:0] op,
    input  logic [3:0] position,
    input  logic [3:0] range_end,
    input  logic       to_end,
    input  logic [7:0] amount,
    input  logic [7:0] value_byte,
    output logic [7:0] read_byte,
    output logic       answer,
    output logic       status
);

    localparam int IW = $clog2(MAX_BYTES);
    localparam int LW = $clog2(MAX_BYTES + 1);

    logic [7:0]    store_reg [MAX_BYTES];
    logic [LW-1:0] len_reg;
    logic          le_reg, indep_reg;

    logic [3:0]    op_reg, pos_reg, rend_reg;
    logic          to_end_reg;
    logic [7:0]    amt_reg, val_reg;
    logic [7:0]    samt_reg;     // shift distance, or rotate distance modulo length
    logic          long_reg;     // shift of at least the length
    logic [7:0]    rd_reg;
    logic          ans_reg, st_reg;

    logic          rev, up;
    assign rev = !le_reg && !indep_reg;
    assign up  = !indep_reg && le_reg;

    // config and command capture
    logic [4:0] cfg_len;
    always_comb
    begin
        cfg_len = cfg_data[4:0];
        if (cfg_len == 5'd0) cfg_len = 5'd1;
        if ({27'd0, cfg_len} > MAX_BYTES) cfg_len = 5'(MAX_BYTES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LW'(MAX_BYTES < 16 ? MAX_BYTES : 16);
            le_reg    <= 1'b1;
            indep_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LENGTH: len_reg   <= LW'(cfg_len);
                REG_LE:     le_reg    <= cfg_data[0];
                REG_INDEP:  indep_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            pos_reg    <= position;
            rend_reg   <= range_end;
            to_end_reg <= to_end;
            amt_reg    <= amount;
            val_reg    <= value_byte;
        end
    end

    // prep: amount modulo length, by repeated subtract over a short chain
    logic [15:0] m;
    always_comb
    begin
        m = {8'd0, amt_reg};
        for (int b = 7; b >= 0; b--)
            if (m >= (16'(len_reg) << b)) m = m - (16'(len_reg) << b);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            long_reg <= ({1'b0, amt_reg} >= {1'b0, 8'(len_reg)});
            if (op_reg == OP_ROTL || op_reg == OP_ROTR)
                samt_reg <= m[7:0];
            else
                samt_reg <= amt_reg;
        end
    end

    // exec: per-byte source selection, write, read and range tests
    logic [7:0]    nstore [MAX_BYTES];
    logic          dir_up, is_rot, is_shift;
    logic          pos_ok, range_ok, feq, fne;
    logic [7:0]    last;
    logic [IW-1:0] pidx;
    logic [7:0]    rd_n;
    logic          ans_n, st_n;

    always_comb
    begin
        is_shift = (op_reg == OP_SHL) || (op_reg == OP_SHR);
        is_rot   = (op_reg == OP_ROTL) || (op_reg == OP_ROTR);
        dir_up   = (op_reg == OP_SHL || op_reg == OP_ROTL) ? up : !up;
        pos_ok   = 8'(pos_reg) < 8'(len_reg);
        pidx     = rev ? IW'(len_reg - 1'b1 - LW'(pos_reg)) : IW'(pos_reg);
        last     = to_end_reg ? 8'(len_reg) - 8'd1 : 8'(rend_reg);
        range_ok = (8'(pos_reg) <= last) && (last < 8'(len_reg));
        rd_n = 8'd0; ans_n = 1'b0; st_n = 1'b0;
        feq = 1'b0; fne = 1'b0;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            logic [LW:0] src;
            logic [7:0]  li;
            nstore[k] = store_reg[k];
            src = '0;
            li = rev ? 8'(len_reg) - 8'd1 - 8'(k) : 8'(k);
            if (LW'(k) < len_reg)
            begin
                if (li >= 8'(pos_reg) && li <= last)
                begin
                    if (store_reg[k] == val_reg) feq = 1'b1;
                    else fne = 1'b1;
                end
                if (is_shift && samt_reg != 8'd0)
                begin
                    if (long_reg)
                        nstore[k] = val_reg;
                    else if (dir_up)
                    begin
                        if (k >= samt_reg) nstore[k] = store_reg[IW'(k - samt_reg)];
                        else nstore[k] = val_reg;
                    end
                    else
                    begin
                        if (k + samt_reg < len_reg)
                            nstore[k] = store_reg[IW'(k + samt_reg)];
                        else nstore[k] = val_reg;
                    end
                end
                else if (is_rot && samt_reg != 8'd0)
                begin
                    if (dir_up)
                        src = (k >= samt_reg) ? (LW+1)'(k - samt_reg)
                                              : (LW+1)'(k + len_reg - samt_reg);
                    else
                        src = (k + samt_reg < len_reg) ? (LW+1)'(k + samt_reg)
                                                       : (LW+1)'(k + samt_reg - len_reg);
                    nstore[k] = store_reg[IW'(src)];
                end
            end
        end
        if (op_reg == OP_WRITE)
        begin
            if (pos_ok) nstore[pidx] = val_reg;
            else st_n = 1'b1;
        end
        else if (op_reg == OP_READ)
        begin
            if (pos_ok) rd_n = store_reg[pidx];
            else st_n = 1'b1;
        end
        else if (op_reg == OP_ALL || op_reg == OP_ANY || op_reg == OP_NONE)
        begin
            if (!range_ok) st_n = 1'b1;
            else if (op_reg == OP_ALL) ans_n = !fne;
            else if (op_reg == OP_ANY) ans_n = feq;
            else ans_n = !feq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_BYTES; k++) store_reg[k] <= 8'd0;
        end
        else if (cmd.exec)
        begin
            for (int k = 0; k < MAX_BYTES; k++) store_reg[k] <= nstore[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rd_reg  <= rd_n;
            ans_reg <= ans_n;
            st_reg  <= st_n;
        end
    end

    assign read_byte = rd_reg;
    assign answer    = ans_reg;
    assign status    = st_reg;

endmodule

// ----- design/byte_buffer_shift_rotate_engine.sv -----
// Byte buffer shift/rotate engine.
// Keeps a store of MAX_BYTES bytes, the first active_length of which are in use.
// Request channel: in_valid/in_ready with op, position, range_end, to_end,
// amount and value_byte; ops are write, read, shift, rotate and range tests.
// Result channel: out_valid/out_ready with read_byte, answer and status; one
// result per request.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data
// (0 active_length, 1 little_endian, 2 independent_mode). Always ready;
// write only while idle.
// After acceptance, the request passes capture, modulo of the rotate distance
// and store update before out_valid rises. One request at a time: the next
// is taken only after the result is taken, as the controller sequence sets.
// While out_ready is low the result is held and no new request is taken.
// Reset clears the store to zero, length 16, little-endian, dependent mode.
module byte_buffer_shift_rotate_engine
    import bbsr_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic [3:0] position,
    input  logic [3:0] range_end,
    input  logic       to_end,
    input  logic [7:0] amount,
    input  logic [7:0] value_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_byte,
    output logic       answer,
    output logic       status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    bbsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bbsr_dp #(.MAX_BYTES(MAX_BYTES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .position   (position),
        .range_end  (range_end),
        .to_end     (to_end),
        .amount     (amount),
        .value_byte (value_byte),
        .read_byte  (read_byte),
        .answer     (answer),
        .status     (status)
    );

endmodule

// ----- design/bbsr_checker.sv -----
module bbsr_sva
    import bbsr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [3:0] op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_byte,
    input logic       answer,
    input logic       status
);

    // no new request while a result waits
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("request taken with result pending");

    // result appears once the PREP and EXEC states have passed after acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##3 out_valid) else $error("result late");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_byte)
        && $stable(answer) && $stable(status))) else $error("result dropped");

    // read byte only from a read
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op != OP_READ) |-> ##3 (read_byte == 8'd0))
        else $error("stray read byte");

endmodule

bind byte_buffer_shift_rotate_engine bbsr_sva u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_byte (read_byte),
    .answer    (answer),
    .status    (status)
);

// ----- bench/bbsr_checker.sv -----
`timescale 1ns / 100ps

module bbsr_checker
    import bbsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [3:0] op,
    input  logic [3:0] position,
    input  logic [3:0] range_end,
    input  logic       to_end,
    input  logic [7:0] amount,
    input  logic [7:0] value_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] read_byte,
    input  logic       answer,
    input  logic       status,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] rd;
        logic       ans;
        logic       st;
    } outcome_t;

    logic [7:0] mirror_store [16];
    int         len_now;
    logic       le_now;
    logic       indep_now;
    outcome_t   awaited_q [$];

    assign pending = awaited_q.size();

    // logical to physical byte index
    function automatic int phys(input int i);
        return (!le_now && !indep_now) ? (len_now - 1 - i) : i;
    endfunction

    // shift (is_rot=0) or rotate the active bytes, up = towards higher index
    function automatic void move_bytes(input bit up, input bit is_rot, input int s,
                                       input logic [7:0] fill);
        logic [7:0] tmp [16];
        int n;
        n = len_now;
        if (is_rot) s = s % n;
        if (s == 0) return;
        for (int k = 0; k < n; k++)
        begin
            if (is_rot)
                tmp[k] = up ? mirror_store[(k + n - s) % n] : mirror_store[(k + s) % n];
            else if (s >= n)
                tmp[k] = fill;
            else if (up)
                tmp[k] = (k >= s) ? mirror_store[k - s] : fill;
            else
                tmp[k] = (k + s < n) ? mirror_store[k + s] : fill;
        end
        for (int k = 0; k < n; k++) mirror_store[k] = tmp[k];
    endfunction

    // work out the result of one request and update the mirror
    function automatic outcome_t apply_request(input logic [3:0] o, input int p, input int re,
                                               input bit te, input int amt,
                                               input logic [7:0] v);
        outcome_t r;
        bit up_left, eq, ne;
        int last;
        r = '0;
        up_left = !indep_now && le_now;
        case (o)
            OP_WRITE:
                if (p < len_now) mirror_store[phys(p)] = v;
                else r.st = 1'b1;
            OP_READ:
                if (p < len_now) r.rd = mirror_store[phys(p)];
                else r.st = 1'b1;
            OP_SHL:  move_bytes(up_left, 1'b0, amt, v);
            OP_SHR:  move_bytes(!up_left, 1'b0, amt, v);
            OP_ROTL: move_bytes(up_left, 1'b1, amt, v);
            OP_ROTR: move_bytes(!up_left, 1'b1, amt, v);
            OP_ALL, OP_ANY, OP_NONE:
            begin
                last = te ? len_now - 1 : re;
                eq = 0;
                ne = 0;
                if (p > last || last >= len_now)
                    r.st = 1'b1;
                else
                begin
                    for (int i = p; i <= last; i++)
                        if (mirror_store[phys(i)] == v) eq = 1; else ne = 1;
                    if (o == OP_ALL)      r.ans = !ne;
                    else if (o == OP_ANY) r.ans = eq;
                    else                  r.ans = !eq;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++) mirror_store[k] = '0;
            len_now = 16;
            le_now = 1'b1;
            indep_now = 1'b0;
            awaited_q.delete();
            fail_count = 0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LENGTH:
                    begin
                        len_now = cfg_data[4:0];
                        if (len_now == 0) len_now = 1;
                        if (len_now > 16) len_now = 16;
                    end
                    REG_LE:    le_now = cfg_data[0];
                    REG_INDEP: indep_now = cfg_data[0];
                    default: ;
                endcase
            end
            // results against oldest expectation
            if (out_valid && out_ready)
            begin
                if (awaited_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    e = awaited_q.pop_front();
                    if (read_byte !== e.rd)
                    begin
                        $error("read_byte expected %0h actual %0h", e.rd, read_byte);
                        fail_count++;
                    end
                    if (answer !== e.ans)
                    begin
                        $error("answer expected %0b actual %0b", e.ans, answer);
                        fail_count++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status expected %0b actual %0b", e.st, status);
                        fail_count++;
                    end
                end
            end
            // accepted requests
            if (in_valid && in_ready)
                awaited_q.push_back(apply_request(op, position, range_end, to_end,
                                                  amount, value_byte));
        end
    end

endmodule

// ----- bench/tb_byte_buffer_shift_rotate_engine.sv -----
`timescale 1ns / 100ps

module tb_byte_buffer_shift_rotate_engine;
    import bbsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [3:0] op = '0;
    logic [3:0] position = '0;
    logic [3:0] range_end = '0;
    logic       to_end = 1'b0;
    logic [7:0] amount = '0;
    logic [7:0] value_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_byte;
    logic       answer;
    logic       status;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    bit         calm = 1'b0;
    bit         hold_results = 1'b0;

    always #5 clk = ~clk;

    byte_buffer_shift_rotate_engine DUT (.*);

    bbsr_checker u_checker (.*);

    // receiver: random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_results)      out_ready <= 1'b0;
        else if (calm)         out_ready <= 1'b1;
        else                   out_ready <= ($urandom_range(99) >= 18);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // valid stays high after acceptance until the next request or a drain
    task automatic send_request(input logic [3:0] o, input logic [3:0] p, input logic [3:0] re,
                                input logic te, input logic [7:0] amt, input logic [7:0] v);
        if (!calm)
            while ($urandom_range(99) < 18)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        op <= o;
        position <= p;
        range_end <= re;
        to_end <= te;
        amount <= amt;
        value_byte <= v;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic random_request;
        logic [3:0] o;
        int r;
        r = $urandom_range(99);
        if (r < 25)      o = OP_WRITE;
        else if (r < 40) o = OP_READ;
        else if (r < 85) o = 4'($urandom_range(2, 8));
        else if (r < 90) o = 4'($urandom_range(9, 15));
        else             o = 4'($urandom_range(0, 15));
        send_request(o, 4'($urandom), 4'($urandom), 1'($urandom),
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20)),
                     ($urandom_range(2) == 0) ? 8'($urandom_range(3)) : 8'($urandom));
    endtask

    task automatic random_config;
        int r;
        r = $urandom_range(9);
        write_reg(REG_LENGTH, (r == 0) ? 8'd1 : (r == 1) ? 8'd16 :
                  (r == 2) ? 8'($urandom) : 8'($urandom_range(1, 16)));
        write_reg(REG_LE, 8'($urandom));
        write_reg(REG_INDEP, 8'($urandom));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation, range corner cases
        send_request(OP_WRITE, 4'd0, 4'd0, 1'b0, 8'd0, 8'hFF);
        send_request(OP_WRITE, 4'd15, 4'd0, 1'b0, 8'd0, 8'hA5);
        send_request(OP_READ, 4'd0, 4'd0, 1'b0, 8'd0, 8'd0);
        send_request(OP_READ, 4'd15, 4'd0, 1'b0, 8'd0, 8'd0);
        send_request(OP_SHL, 4'd0, 4'd0, 1'b0, 8'd0, 8'h11);
        send_request(OP_SHL, 4'd0, 4'd0, 1'b0, 8'd3, 8'h11);
        send_request(OP_SHR, 4'd0, 4'd0, 1'b0, 8'd255, 8'h5A);
        send_request(OP_WRITE, 4'd3, 4'd0, 1'b0, 8'd0, 8'h01);
        send_request(OP_ROTL, 4'd0, 4'd0, 1'b0, 8'd17, 8'd0);
        send_request(OP_ROTR, 4'd0, 4'd0, 1'b0, 8'd255, 8'd0);
        send_request(OP_ROTL, 4'd0, 4'd0, 1'b0, 8'd16, 8'd0);
        send_request(OP_ALL, 4'd0, 4'd0, 1'b1, 8'd0, 8'h5A);
        send_request(OP_ANY, 4'd0, 4'd15, 1'b0, 8'd0, 8'h01);
        send_request(OP_NONE, 4'd2, 4'd5, 1'b0, 8'd0, 8'h01);
        send_request(OP_ALL, 4'd5, 4'd2, 1'b0, 8'd0, 8'h5A);
        send_request(OP_ANY, 4'd15, 4'd15, 1'b0, 8'd0, 8'h5A);
        send_request(4'd15, 4'd15, 4'd15, 1'b1, 8'hFF, 8'hFF);
        drain();

        write_reg(REG_LENGTH, 8'd0);
        write_reg(REG_LE, 8'd0);
        write_reg(REG_INDEP, 8'd0);
        send_request(OP_WRITE, 4'd1, 4'd0, 1'b0, 8'd0, 8'h77);
        send_request(OP_WRITE, 4'd0, 4'd0, 1'b0, 8'd0, 8'h33);
        send_request(OP_ANY, 4'd0, 4'd0, 1'b1, 8'd0, 8'h33);
        send_request(OP_SHL, 4'd0, 4'd0, 1'b0, 8'd1, 8'h44);
        drain();
        write_reg(REG_LENGTH, 8'h1F);
        write_reg(REG_INDEP, 8'd1);
        send_request(OP_ANY, 4'd3, 4'd15, 1'b0, 8'd0, 8'h33);
        drain();

        // random phases with fresh settings
        for (int ph = 0; ph < 35; ph++)
        begin
            calm = (ph == 4);
            random_config();
            if (ph == 10)
            begin
                // receiver holds off while requests keep coming
                fork
                    begin
                        hold_results = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_results = 1'b0;
                    end
                    repeat (50) random_request();
                join
            end
            else
                repeat (50) random_request();
            drain();
        end
        calm = 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bbsr_pkg.sv
design/bbsr_ctrl.sv
design/bbsr_dp.sv
design/byte_buffer_shift_rotate_engine.sv
design/bbsr_checker.sv
bench/bbsr_checker.sv
bench/tb_byte_buffer_shift_rotate_engine.sv
